/* hw/rtl/q2e_pkg.sv */
// shared constants, types and the arctangent table for the quaternion to euler block
`timescale 1ns / 1ps
package q2e_pkg;

  localparam int COMP_W     = 16;
  localparam int ANG_F      = 12;
  localparam int STAGES_DEF = 16;
  localparam int ZFRAC      = 60;
  localparam int OP_W       = 32;
  localparam int CW         = 60;
  localparam int ZW         = 64;
  localparam int SQ_W       = 62;
  localparam int SQ_STEPS   = 31;
  localparam int OUT_SH     = ZFRAC - ANG_F;
  localparam int RND_W      = ZW - OUT_SH;
  localparam int ROLL_W     = ANG_F + 3;
  localparam int PITCH_W    = ANG_F + 2;
  localparam int TAB_N      = 32;
  localparam int NORM_MSB   = 55;
  localparam int SH_W       = 6;
  localparam int MSB_W      = 5;
  localparam int NUM_SLOTS  = 2;
  localparam int NUM_LANES  = 3;
  localparam int LANE_ROLL  = 0;
  localparam int LANE_PITCH = 1;
  localparam int LANE_YAW   = 2;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [ZW-1:0] z;
  } lane_t;

  typedef struct packed {
    logic                 vld;
    logic                 slot;
    logic [NUM_LANES-1:0] zero;
  } tag_t;

  typedef struct packed {
    logic signed [OP_W-1:0] ra;
    logic signed [OP_W-1:0] rb;
    logic signed [OP_W-1:0] ya;
    logic signed [OP_W-1:0] yb;
    logic signed [OP_W-1:0] s30;
  } ops_t;

  // long division, used only while the table is built
  function automatic logic [63:0] udiv(input logic [63:0] num, input logic [63:0] den);
    logic [64:0] rem;
    logic [63:0] q;
    rem = '0;
    q   = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], num[b]};
      if (rem >= {1'b0, den}) begin
        rem  = rem - {1'b0, den};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // atan(2^-i) from its power series, entry 0 is atan(1/2) + atan(1/3)
  function automatic logic [TAB_N-1:0][63:0] build_tab();
    logic [TAB_N-1:0][63:0] tab;
    logic [63:0] acc;
    logic [63:0] term;
    logic [63:0] part;
    logic [63:0] den;
    int e;
    tab = '0;
    for (int i = 1; i < TAB_N; i++) begin
      acc = '0;
      for (int k = 0; k < 31; k++) begin
        e = i * (2 * k + 1);
        if (e <= ZFRAC) begin
          term = udiv(64'd1 << (ZFRAC - e), 64'(2 * k + 1));
          if (k[0]) acc = acc - term;
          else acc = acc + term;
        end
      end
      tab[i] = acc;
    end
    acc  = '0;
    term = udiv(64'd1 << ZFRAC, 64'd3);
    den  = 64'd1;
    for (int k = 0; k < 48; k++) begin
      if (term != '0) begin
        part = udiv(term, den);
        if (k[0]) acc = acc - part;
        else acc = acc + part;
        term = udiv(term, 64'd9);
        den  = den + 64'd2;
      end
    end
    tab[0] = tab[1] + acc;
    return tab;
  endfunction

  localparam logic [TAB_N-1:0][63:0] ATAN_TAB = build_tab();
  localparam logic signed [ZW-1:0] PI_Z = signed'({ATAN_TAB[0][ZW-3:0], 2'b00});
  localparam logic signed [ZW-1:0] RND_HALF =
    signed'({{(ZW-OUT_SH){1'b0}}, 1'b1, {(OUT_SH-1){1'b0}}});
  localparam logic signed [ZW-1:0] PI_RND  = (PI_Z + RND_HALF) >>> OUT_SH;
  localparam logic signed [ZW-1:0] HPI_RND = ((PI_Z >>> 1) + RND_HALF) >>> OUT_SH;
  localparam logic signed [RND_W-1:0] LIM_PI  = PI_RND[RND_W-1:0];
  localparam logic signed [RND_W-1:0] LIM_HPI = HPI_RND[RND_W-1:0];

endpackage

/* hw/rtl/q2e_sqrt_cell.sv */
// one restoring square root step, with the atan2 operands riding along
`timescale 1ns / 1ps
module q2e_sqrt_cell #(
  parameter int K = 0
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic [q2e_pkg::SQ_W-1:0]   v_i,
  input  logic [q2e_pkg::SQ_W-1:0]   q_i,
  input  q2e_pkg::ops_t              ops_i,
  input  q2e_pkg::tag_t              tag_i,
  output logic [q2e_pkg::SQ_W-1:0]   v_r,
  output logic [q2e_pkg::SQ_W-1:0]   q_r,
  output q2e_pkg::ops_t              ops_r,
  output q2e_pkg::tag_t              tag_r
);

  localparam logic [q2e_pkg::SQ_W-1:0] BIT = q2e_pkg::SQ_W'(64'd1 << (2 * K));

  logic [q2e_pkg::SQ_W-1:0] trial;
  logic [q2e_pkg::SQ_W-1:0] v_nxt;
  logic [q2e_pkg::SQ_W-1:0] q_nxt;

  always_comb begin
    trial = q_i + BIT;
    if (v_i >= trial) begin
      v_nxt = v_i - trial;
      q_nxt = (q_i >> 1) + BIT;
    end else begin
      v_nxt = v_i;
      q_nxt = q_i >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r <= '0;
    end else if (en) begin
      tag_r <= tag_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      v_r   <= v_nxt;
      q_r   <= q_nxt;
      ops_r <= ops_i;
    end
  end

endmodule

/* hw/rtl/q2e_norm.sv */
// scales one atan2 operand pair to a fixed magnitude and turns it into the right half plane
`timescale 1ns / 1ps
module q2e_norm (
  input  logic                              clk,
  input  logic                              en,
  input  logic signed [q2e_pkg::OP_W-1:0]   x_i,
  input  logic signed [q2e_pkg::OP_W-1:0]   y_i,
  output q2e_pkg::lane_t                    lane_r,
  output logic                              zero_r
);

  logic [q2e_pkg::OP_W-1:0]          ax;
  logic [q2e_pkg::OP_W-1:0]          ay;
  logic [q2e_pkg::OP_W-1:0]          m;
  logic [q2e_pkg::MSB_W-1:0]         msb;
  logic signed [q2e_pkg::OP_W-1:0]   xa_r;
  logic signed [q2e_pkg::OP_W-1:0]   ya_r;
  logic [q2e_pkg::SH_W-1:0]          sh_r;
  logic                              za_r;
  logic signed [q2e_pkg::CW-1:0]     xs;
  logic signed [q2e_pkg::CW-1:0]     ys;
  q2e_pkg::lane_t                    lane_nxt;

  always_comb begin
    ax  = x_i[q2e_pkg::OP_W-1] ? -x_i : x_i;
    ay  = y_i[q2e_pkg::OP_W-1] ? -y_i : y_i;
    m   = (ax > ay) ? ax : ay;
    msb = '0;
    for (int b = 0; b < q2e_pkg::OP_W; b++) begin
      if (m[b]) msb = q2e_pkg::MSB_W'(b);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xa_r <= x_i;
      ya_r <= y_i;
      sh_r <= q2e_pkg::SH_W'(q2e_pkg::NORM_MSB) - {1'b0, msb};
      za_r <= (m == '0);
    end
  end

  // negative x: rotate by pi, sign of the offset follows y
  always_comb begin
    xs = {{(q2e_pkg::CW-q2e_pkg::OP_W){xa_r[q2e_pkg::OP_W-1]}}, xa_r} <<< sh_r;
    ys = {{(q2e_pkg::CW-q2e_pkg::OP_W){ya_r[q2e_pkg::OP_W-1]}}, ya_r} <<< sh_r;
    if (xs[q2e_pkg::CW-1]) begin
      lane_nxt.x = -xs;
      lane_nxt.y = -ys;
      lane_nxt.z = ys[q2e_pkg::CW-1] ? -q2e_pkg::PI_Z : q2e_pkg::PI_Z;
    end else begin
      lane_nxt.x = xs;
      lane_nxt.y = ys;
      lane_nxt.z = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lane_r <= lane_nxt;
      zero_r <= za_r;
    end
  end

endmodule

/* hw/rtl/q2e_cordic_cell.sv */
// one vectoring cordic micro rotation for the roll, pitch and yaw lanes
`timescale 1ns / 1ps
module q2e_cordic_cell #(
  parameter int IDX = 0
) (
  input  logic                                          clk,
  input  logic                                          rst_n,
  input  logic                                          en,
  input  q2e_pkg::lane_t [q2e_pkg::NUM_LANES-1:0]       lane_i,
  input  q2e_pkg::tag_t                                 tag_i,
  output q2e_pkg::lane_t [q2e_pkg::NUM_LANES-1:0]       lane_r,
  output q2e_pkg::tag_t                                 tag_r
);

  localparam logic signed [q2e_pkg::ZW-1:0] ANG = signed'(q2e_pkg::ATAN_TAB[IDX]);

  q2e_pkg::lane_t [q2e_pkg::NUM_LANES-1:0] lane_nxt;
  logic signed [q2e_pkg::CW-1:0] xsh [q2e_pkg::NUM_LANES];
  logic signed [q2e_pkg::CW-1:0] ysh [q2e_pkg::NUM_LANES];

  always_comb begin
    for (int l = 0; l < q2e_pkg::NUM_LANES; l++) begin
      xsh[l] = $signed(lane_i[l].x) >>> IDX;
      ysh[l] = $signed(lane_i[l].y) >>> IDX;
      if (!lane_i[l].y[q2e_pkg::CW-1]) begin
        lane_nxt[l].x = lane_i[l].x + ysh[l];
        lane_nxt[l].y = lane_i[l].y - xsh[l];
        lane_nxt[l].z = lane_i[l].z + ANG;
      end else begin
        lane_nxt[l].x = lane_i[l].x - ysh[l];
        lane_nxt[l].y = lane_i[l].y + xsh[l];
        lane_nxt[l].z = lane_i[l].z - ANG;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r <= '0;
    end else if (en) begin
      tag_r <= tag_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lane_r <= lane_nxt;
    end
  end

endmodule

/* hw/rtl/quaternion_to_euler_angles.sv */
// top level: quaternion to roll, pitch and yaw through square root and cordic cell chains
//
//   channel | ports                                   | direction
//   input   | in_valid in_ready in_quat_* in_device_slot | in
//   result  | out_valid out_ready out_*_angle out_slot_out | out
//
// one transaction per cycle sustained while in_ready stays high; most of the latency
// comes from the 31 square root cells and the cordic chain
// slots above one are accepted and dropped
// rst_n clears all valid bits; a stalled result sits in the output register while the
// pipeline keeps moving, and a skid register takes the next one before input stalls
`timescale 1ns / 1ps
module quaternion_to_euler_angles #(
  parameter int CORDIC_STAGES = q2e_pkg::STAGES_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [q2e_pkg::COMP_W-1:0]    in_quat_w,
  input  logic signed [q2e_pkg::COMP_W-1:0]    in_quat_x,
  input  logic signed [q2e_pkg::COMP_W-1:0]    in_quat_y,
  input  logic signed [q2e_pkg::COMP_W-1:0]    in_quat_z,
  input  logic [1:0]                           in_device_slot,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [q2e_pkg::ROLL_W-1:0]    out_roll_angle,
  output logic signed [q2e_pkg::PITCH_W-1:0]   out_pitch_angle,
  output logic signed [q2e_pkg::ROLL_W-1:0]    out_yaw_angle,
  output logic                                 out_slot_out
);

  localparam int PR_W = 2 * q2e_pkg::COMP_W - 2;
  localparam int SQR_W = 2 * q2e_pkg::OP_W;
  localparam logic signed [q2e_pkg::OP_W-1:0] ONE =
    q2e_pkg::OP_W'(64'd1 << (2 * q2e_pkg::COMP_W - 6));
  localparam logic [q2e_pkg::SQ_W-1:0] RAD_ONE = q2e_pkg::SQ_W'(64'd1 << q2e_pkg::ZFRAC);

  function automatic logic signed [PR_W-1:0] qmul(
    input logic signed [q2e_pkg::COMP_W-1:0] a,
    input logic signed [q2e_pkg::COMP_W-1:0] b
  );
    logic signed [2*q2e_pkg::COMP_W-1:0] p;
    p = a * b;
    return p[2*q2e_pkg::COMP_W-1:2];
  endfunction

  function automatic logic signed [q2e_pkg::OP_W-1:0] ext(input logic signed [PR_W-1:0] a);
    return {{(q2e_pkg::OP_W-PR_W){a[PR_W-1]}}, a};
  endfunction

  function automatic logic signed [q2e_pkg::RND_W-1:0] to_ang(
    input logic signed [q2e_pkg::ZW-1:0]    z,
    input logic signed [q2e_pkg::RND_W-1:0] lim,
    input logic                             zero
  );
    logic signed [q2e_pkg::ZW-1:0]    t;
    logic signed [q2e_pkg::RND_W-1:0] v;
    t = z + q2e_pkg::RND_HALF;
    v = t[q2e_pkg::ZW-1:q2e_pkg::OUT_SH];
    if (v > lim) v = lim;
    else if (v < -lim) v = -lim;
    if (zero) v = '0;
    return v;
  endfunction

  logic en;
  logic skid_v_r;
  logic out_v_r;

  assign en       = !skid_v_r;
  assign in_ready = en;

  // stage 1: input register
  logic signed [q2e_pkg::COMP_W-1:0] w_r, x_r, y_r, z_r;
  q2e_pkg::tag_t t1_r, t2_r, t3_r, t4_r, t5_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t1_r <= '0;
      t2_r <= '0;
      t3_r <= '0;
      t4_r <= '0;
      t5_r <= '0;
    end else if (en) begin
      t1_r.vld  <= in_valid && (in_device_slot < 2'(q2e_pkg::NUM_SLOTS));
      t1_r.slot <= in_device_slot[0];
      t1_r.zero <= '0;
      t2_r <= t1_r;
      t3_r <= t2_r;
      t4_r <= t3_r;
      t5_r <= t4_r;
    end
  end

  // stage 2: component products, stage 3: operand sums
  logic signed [PR_W-1:0] wx_r, yz_r, xx_r, yy_r, zz_r, wz_r, xy_r, wy_r, zx_r;
  logic signed [q2e_pkg::OP_W-1:0] s_raw;
  logic signed [q2e_pkg::OP_W-1:0] s_clp;
  q2e_pkg::ops_t ops_nxt, ops3_r, ops4_r, ops5_r;
  logic signed [SQR_W-1:0] sq_full;
  logic [q2e_pkg::SQ_W-1:0] sq_r;
  logic [q2e_pkg::SQ_W-1:0] rad_r;

  always_comb begin
    s_raw = (ext(wy_r) - ext(zx_r)) <<< 1;
    if (s_raw > ONE) s_clp = ONE;
    else if (s_raw < -ONE) s_clp = -ONE;
    else s_clp = s_raw;
    ops_nxt.ra  = (ext(wx_r) + ext(yz_r)) <<< 1;
    ops_nxt.rb  = ONE - ((ext(xx_r) + ext(yy_r)) <<< 1);
    ops_nxt.ya  = (ext(wz_r) + ext(xy_r)) <<< 1;
    ops_nxt.yb  = ONE - ((ext(yy_r) + ext(zz_r)) <<< 1);
    ops_nxt.s30 = s_clp <<< 4;
    sq_full     = ops3_r.s30 * ops3_r.s30;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      w_r    <= in_quat_w;
      x_r    <= in_quat_x;
      y_r    <= in_quat_y;
      z_r    <= in_quat_z;
      wx_r   <= qmul(w_r, x_r);
      yz_r   <= qmul(y_r, z_r);
      xx_r   <= qmul(x_r, x_r);
      yy_r   <= qmul(y_r, y_r);
      zz_r   <= qmul(z_r, z_r);
      wz_r   <= qmul(w_r, z_r);
      xy_r   <= qmul(x_r, y_r);
      wy_r   <= qmul(w_r, y_r);
      zx_r   <= qmul(z_r, x_r);
      ops3_r <= ops_nxt;
      ops4_r <= ops3_r;
      sq_r   <= sq_full[q2e_pkg::SQ_W-1:0];
      ops5_r <= ops4_r;
      rad_r  <= RAD_ONE - sq_r;
    end
  end

  // square root chain for the pitch cosine
  logic [q2e_pkg::SQ_W-1:0] sv [q2e_pkg::SQ_STEPS+1];
  logic [q2e_pkg::SQ_W-1:0] sr [q2e_pkg::SQ_STEPS+1];
  q2e_pkg::ops_t            so [q2e_pkg::SQ_STEPS+1];
  q2e_pkg::tag_t            st [q2e_pkg::SQ_STEPS+1];

  assign sv[0] = rad_r;
  assign sr[0] = '0;
  assign so[0] = ops5_r;
  assign st[0] = t5_r;

  for (genvar j = 0; j < q2e_pkg::SQ_STEPS; j++) begin : g_sqrt
    q2e_sqrt_cell #(
      .K(q2e_pkg::SQ_STEPS - 1 - j)
    ) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .v_i   (sv[j]),
      .q_i   (sr[j]),
      .ops_i (so[j]),
      .tag_i (st[j]),
      .v_r   (sv[j+1]),
      .q_r   (sr[j+1]),
      .ops_r (so[j+1]),
      .tag_r (st[j+1])
    );
  end

  // normalization, two stages
  q2e_pkg::ops_t ops_e;
  logic signed [q2e_pkg::OP_W-1:0] c30;
  q2e_pkg::lane_t [q2e_pkg::NUM_LANES-1:0] nl;
  logic [q2e_pkg::NUM_LANES-1:0] nz;
  q2e_pkg::tag_t tna_r, tnb_r;

  assign ops_e = so[q2e_pkg::SQ_STEPS];
  assign c30   = signed'(q2e_pkg::OP_W'(sr[q2e_pkg::SQ_STEPS][q2e_pkg::OP_W-2:0]));

  q2e_norm u_norm_roll (
    .clk    (clk),
    .en     (en),
    .x_i    (ops_e.rb),
    .y_i    (ops_e.ra),
    .lane_r (nl[q2e_pkg::LANE_ROLL]),
    .zero_r (nz[q2e_pkg::LANE_ROLL])
  );

  q2e_norm u_norm_pitch (
    .clk    (clk),
    .en     (en),
    .x_i    (c30),
    .y_i    (ops_e.s30),
    .lane_r (nl[q2e_pkg::LANE_PITCH]),
    .zero_r (nz[q2e_pkg::LANE_PITCH])
  );

  q2e_norm u_norm_yaw (
    .clk    (clk),
    .en     (en),
    .x_i    (ops_e.yb),
    .y_i    (ops_e.ya),
    .lane_r (nl[q2e_pkg::LANE_YAW]),
    .zero_r (nz[q2e_pkg::LANE_YAW])
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tna_r <= '0;
      tnb_r <= '0;
    end else if (en) begin
      tna_r <= st[q2e_pkg::SQ_STEPS];
      tnb_r <= tna_r;
    end
  end

  // cordic chain
  q2e_pkg::lane_t [q2e_pkg::NUM_LANES-1:0] cl [CORDIC_STAGES+1];
  q2e_pkg::tag_t                           ct [CORDIC_STAGES+1];

  assign cl[0]      = nl;
  assign ct[0].vld  = tnb_r.vld;
  assign ct[0].slot = tnb_r.slot;
  assign ct[0].zero = nz;

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
    q2e_cordic_cell #(
      .IDX(i)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en),
      .lane_i (cl[i]),
      .tag_i  (ct[i]),
      .lane_r (cl[i+1]),
      .tag_r  (ct[i+1])
    );
  end

  // rounding, saturation and the output / skid registers
  q2e_pkg::lane_t [q2e_pkg::NUM_LANES-1:0] ce;
  q2e_pkg::tag_t te;
  logic signed [q2e_pkg::RND_W-1:0] a_roll, a_pitch, a_yaw;
  logic signed [q2e_pkg::ROLL_W-1:0]  roll_r, yaw_r, sk_roll_r, sk_yaw_r;
  logic signed [q2e_pkg::PITCH_W-1:0] pitch_r, sk_pitch_r;
  logic slot_r, sk_slot_r;

  assign ce = cl[CORDIC_STAGES];
  assign te = ct[CORDIC_STAGES];

  always_comb begin
    a_roll  = to_ang(ce[q2e_pkg::LANE_ROLL].z, q2e_pkg::LIM_PI,
                     te.zero[q2e_pkg::LANE_ROLL]);
    a_pitch = to_ang(ce[q2e_pkg::LANE_PITCH].z, q2e_pkg::LIM_HPI,
                     te.zero[q2e_pkg::LANE_PITCH]);
    a_yaw   = to_ang(ce[q2e_pkg::LANE_YAW].z, q2e_pkg::LIM_PI,
                     te.zero[q2e_pkg::LANE_YAW]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (out_v_r && !out_ready) begin
      if (en && te.vld) skid_v_r <= 1'b1;
    end else if (skid_v_r) begin
      out_v_r  <= 1'b1;
      skid_v_r <= 1'b0;
    end else begin
      out_v_r <= te.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (out_v_r && !out_ready) begin
      if (en) begin
        sk_roll_r  <= a_roll[q2e_pkg::ROLL_W-1:0];
        sk_pitch_r <= a_pitch[q2e_pkg::PITCH_W-1:0];
        sk_yaw_r   <= a_yaw[q2e_pkg::ROLL_W-1:0];
        sk_slot_r  <= te.slot;
      end
    end else if (skid_v_r) begin
      roll_r  <= sk_roll_r;
      pitch_r <= sk_pitch_r;
      yaw_r   <= sk_yaw_r;
      slot_r  <= sk_slot_r;
    end else begin
      roll_r  <= a_roll[q2e_pkg::ROLL_W-1:0];
      pitch_r <= a_pitch[q2e_pkg::PITCH_W-1:0];
      yaw_r   <= a_yaw[q2e_pkg::ROLL_W-1:0];
      slot_r  <= te.slot;
    end
  end

  assign out_valid       = out_v_r;
  assign out_roll_angle  = roll_r;
  assign out_pitch_angle = pitch_r;
  assign out_yaw_angle   = yaw_r;
  assign out_slot_out    = slot_r;

endmodule
